### rtl/lis_pkg.sv
// ============================================================================
// lis_pkg: shared types and constants
// Sizes, the word that travels along the cell chain, and the control states.
// ============================================================================
package lis_pkg;

  localparam int MAX_N   = 1024;                 // stored entries, one per cell
  localparam int VAL_W   = 32;
  localparam int LEN_W   = 11;
  localparam int CNT_W   = $clog2(MAX_N + 1);    // holds 0..MAX_N
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_N);

  // Word handed from cell to cell while an item is scanned.
  typedef struct packed {
    logic                    vld;     // word present
    logic signed [VAL_W-1:0] value;   // incoming element
    logic [LEN_W-1:0]        len;     // best length so far for this element
    logic [CNT_W-1:0]        remain;  // cells left before the free one
    logic                    stored;  // already written into its cell
  } tok_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

endpackage

### rtl/lis_cell.sv
// ============================================================================
// lis_cell: one entry of the scan chain
// Holds one stored element and its length; updates the passing word.
// ============================================================================
module lis_cell
  import lis_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  tok_t tok_in,
  output tok_t tok_out
);

  tok_t                    tok_r;
  tok_t                    tok_nxt;
  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] val_nxt;
  logic [LEN_W-1:0]        len_r;
  logic [LEN_W-1:0]        len_nxt;
  logic [LEN_W-1:0]        cand;

  // saturating length + 1
  assign cand = (len_r == LEN_MAX) ? len_r : len_r + LEN_W'(1);

  always_comb begin
    tok_nxt = tok_in;
    val_nxt = val_r;
    len_nxt = len_r;
    if (tok_in.vld && !tok_in.stored) begin
      if (tok_in.remain == '0) begin
        // first free entry: store here
        val_nxt        = tok_in.value;
        len_nxt        = tok_in.len;
        tok_nxt.stored = 1'b1;
      end else begin
        if ((val_r < tok_in.value) && (cand > tok_in.len)) begin
          tok_nxt.len = cand;
        end
        tok_nxt.remain = tok_in.remain - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    len_r <= len_nxt;
  end

  assign tok_out = tok_r;

endmodule

### rtl/longest_increasing_subsequence_top.sv
// ============================================================================
// longest_increasing_subsequence_top: LIS length over a word sequence
// Quadratic DP on a chain of MAX_N cells, one stored element per cell.
// ============================================================================
// Usage:
//  - Input: drive in_value / in_last with start high; the word is taken on
//    an edge where busy is low. in_last marks the final word of a sequence.
//  - Each stored word launches a scan word into cell 0. It walks one cell
//    per cycle, picking up the best length of every smaller earlier entry,
//    and writes itself into the first free cell (index = item count).
//    The scan always walks the whole chain, so an item holds busy until
//    its scan word comes out of the last cell of the chain.
//  - A word arriving with MAX_N entries already stored is not scanned: it
//    sets the overflow flag without raising busy; a last word still reports.
//  - Result: one word per sequence, on out_length / out_overflow with
//    out_strobe high for exactly one cycle, in the cycle after the last
//    item finishes. The receiver cannot stall; it must take it then.
//  - After the result, count, best length and overflow clear for the next
//    sequence. Stored cells are never cleared; they are only read once
//    rewritten in the current sequence.
//  - Reset (rst_n low, synchronous) returns to idle with count, best
//    length and overflow cleared and no scan word in flight.
// ============================================================================
module longest_increasing_subsequence_top
  import lis_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_last,
  output logic                    out_strobe,
  output logic [LEN_W-1:0]        out_length,
  output logic                    out_overflow
);

  // chain links: tok[0] is the launch register, tok[MAX_N] the chain end
  tok_t tok [MAX_N+1];

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [LEN_W-1:0] best_r, best_nxt;
  logic             ovf_r, ovf_nxt;
  logic             last_r, last_nxt;
  tok_t             launch_r, launch_nxt;
  logic             strobe_r, strobe_nxt;
  logic [LEN_W-1:0] olen_r, olen_nxt;
  logic             oovf_r, oovf_nxt;

  logic             accept;
  logic             full;
  logic [LEN_W-1:0] best_upd;

  assign accept   = start && (state_r == ST_IDLE);
  assign full     = (count_r == CNT_FULL);
  assign best_upd = (tok[MAX_N].len > best_r) ? tok[MAX_N].len : best_r;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && !full) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (tok[MAX_N].vld) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- datapath / outputs ----------------
  always_comb begin
    count_nxt  = count_r;
    best_nxt   = best_r;
    ovf_nxt    = ovf_r;
    last_nxt   = last_r;
    launch_nxt = launch_r;
    launch_nxt.vld = 1'b0;
    strobe_nxt = 1'b0;
    olen_nxt   = olen_r;
    oovf_nxt   = oovf_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (full) begin
            // no room: flag only; a last word still reports
            if (in_last) begin
              strobe_nxt = 1'b1;
              olen_nxt   = best_r;
              oovf_nxt   = 1'b1;
              count_nxt  = '0;
              best_nxt   = '0;
              ovf_nxt    = 1'b0;
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            launch_nxt.vld    = 1'b1;
            launch_nxt.value  = in_value;
            launch_nxt.len    = LEN_W'(1);
            launch_nxt.remain = count_r;
            launch_nxt.stored = 1'b0;
            last_nxt          = in_last;
          end
        end
      end
      ST_RUN: begin
        if (tok[MAX_N].vld) begin
          if (last_r) begin
            strobe_nxt = 1'b1;
            olen_nxt   = best_upd;
            oovf_nxt   = ovf_r;
            count_nxt  = '0;
            best_nxt   = '0;
            ovf_nxt    = 1'b0;
          end else begin
            count_nxt = count_r + CNT_W'(1);
            best_nxt  = best_upd;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      best_r       <= '0;
      ovf_r        <= 1'b0;
      launch_r.vld <= 1'b0;
      strobe_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      best_r   <= best_nxt;
      ovf_r    <= ovf_nxt;
      launch_r <= launch_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    olen_r <= olen_nxt;
    oovf_r <= oovf_nxt;
  end

  // ---------------- cell chain ----------------
  assign tok[0] = launch_r;

  for (genvar i = 0; i < MAX_N; i++) begin : g_cell
    lis_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  assign busy         = (state_r == ST_RUN);
  assign out_strobe   = strobe_r;
  assign out_length   = olen_r;
  assign out_overflow = oovf_r;

endmodule

### rtl/lis_chk.sv
// ============================================================================
// lis_chk: port-level checks for the LIS block
// Watches the top-level ports; attached by bind.
// ============================================================================
module lis_chk
  import lis_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             in_last,
  input logic             out_strobe,
  input logic [LEN_W-1:0] out_length
);

  // result only shows once the scan has finished
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  // every sequence stores at least one word
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_length != '0))
    else $error("zero length result");

  // a result clears the state, so two results never touch
  a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back-to-back results");

  // a non-final word never yields a result right away
  a_nonlast_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_last) |=> !out_strobe)
    else $error("result after non-final word");

endmodule

bind longest_increasing_subsequence_top lis_chk u_lis_chk (.*);

### test/longest_increasing_subsequence_top_test.sv
// ============================================================================
// longest_increasing_subsequence_top_test: self-checking LIS testbench
// Drives word sequences through the start/busy handshake and checks each
// result word against a typed-in value or an in-bench quadratic DP
// predictor. It runs a directed table and then random sequences.
// ============================================================================
module longest_increasing_subsequence_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lis_pkg::*;

  // Slowest run: about 580 words, each holding busy for a whole chain scan, plus gaps.
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int RANDOM_WORDS  = 557;
  localparam int DIRECTED_ROWS = 23;
  localparam int MAX_REPORTS   = 10;

  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  // Value flavors for the random sequences.
  typedef enum int {
    FLAVOR_NARROW,   // small range, many ties
    FLAVOR_WIDE,     // any 32-bit pattern
    FLAVOR_CLIMB,    // noisy upward walk, long chains
    FLAVOR_CORNER    // extremes and sign boundary
  } flavor_t;

  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic             overflow;
  } lis_result_t;

  // One row of the directed table. On rows with known set the result word
  // is typed in; all other rows are checked against the predictor.
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    known;
    logic [LEN_W-1:0]        length;
    logic                    overflow;
  } stim_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic signed [VAL_W-1:0] in_value;
  logic                    in_last;
  logic                    out_strobe;
  logic [LEN_W-1:0]        out_length;
  logic                    out_overflow;

  longest_increasing_subsequence_top DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .in_last      (in_last),
    .out_strobe   (out_strobe),
    .out_length   (out_length),
    .out_overflow (out_overflow)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Directed table: single word, both extremes in either order, ties,
  // the sign boundary, near-extreme neighbors, then a classic mixed case.
  // --------------------------------------------------------------------------
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{32'sd7,          1'b1, 1'b1, 11'd1, 1'b0},  // lone word right after reset
    '{VAL_MIN,         1'b0, 1'b0, 11'd0, 1'b0},
    '{VAL_MAX,         1'b1, 1'b1, 11'd2, 1'b0},  // min then max
    '{VAL_MAX,         1'b0, 1'b0, 11'd0, 1'b0},
    '{VAL_MIN,         1'b1, 1'b1, 11'd1, 1'b0},  // max then min
    '{32'sd5,          1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sd5,          1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sd5,          1'b1, 1'b1, 11'd1, 1'b0},  // equal is not increasing
    '{-32'sd1,         1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sd0,          1'b1, 1'b1, 11'd2, 1'b0},  // -1 < 0 across the sign
    '{32'sd0,          1'b0, 1'b0, 11'd0, 1'b0},
    '{-32'sd1,         1'b1, 1'b1, 11'd1, 1'b0},
    '{32'sh7FFF_FFFE,  1'b0, 1'b0, 11'd0, 1'b0},
    '{VAL_MAX,         1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sh8000_0001,  1'b1, 1'b1, 11'd2, 1'b0},
    '{32'sd3,          1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sd1,          1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sd4,          1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sd1,          1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sd5,          1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sd9,          1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sd2,          1'b0, 1'b0, 11'd0, 1'b0},
    '{32'sd6,          1'b1, 1'b0, 11'd0, 1'b0}
  };

  // --------------------------------------------------------------------------
  // Predictor: quadratic DP over the current sequence.
  // --------------------------------------------------------------------------
  logic signed [VAL_W-1:0] seq_values  [MAX_N];
  logic [LEN_W-1:0]        seq_lengths [MAX_N];
  int unsigned             seq_count    = 0;
  logic [LEN_W-1:0]        seq_best     = '0;
  logic                    seq_overflow = 1'b0;

  lis_result_t lis_pending [$];   // result words still owed by the block
  lis_result_t want_result;

  int unsigned cycle_count      = 0;
  int unsigned mismatches       = 0;
  int unsigned words_sent       = 0;
  int unsigned results_seen     = 0;
  int unsigned overflow_results = 0;
  int unsigned longest_seen     = 0;
  bit          idle_enable      = 1'b1;

  // Absorb one accepted word; done is set when it closes a sequence.
  task automatic lis_absorb(input logic signed [VAL_W-1:0] v, input logic l,
                            output bit done, output lis_result_t res);
    int unsigned len;
    int unsigned cand;
    int unsigned j;
    done = 1'b0;
    res  = '0;
    if (seq_count < MAX_N) begin
      len = 1;
      for (j = 0; j < seq_count; j++) begin
        if (seq_values[j] < v) begin
          cand = seq_lengths[j] + 1;
          if (cand > LEN_MAX) cand = LEN_MAX;   // saturate at the field width
          if (cand > len) len = cand;
        end
      end
      seq_values[seq_count]  = v;
      seq_lengths[seq_count] = LEN_W'(len);
      seq_count++;
      if (len > seq_best) seq_best = LEN_W'(len);
    end else begin
      // Capacity reached: word is dropped, only the flag remembers it.
      seq_overflow = 1'b1;
    end
    if (l) begin
      done         = 1'b1;
      res.length   = seq_best;
      res.overflow = seq_overflow;
      seq_count    = 0;
      seq_best     = '0;
      seq_overflow = 1'b0;
    end
  endtask

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Present one word and hold it until the block takes it. Entry and exit
  // are both at a rising edge; start is only lowered when a gap is taken,
  // so it never gets two assignments in one step.
  task automatic send_word(input logic signed [VAL_W-1:0] v, input logic l,
                           input logic known, input lis_result_t typed);
    int unsigned gap;
    bit          done;
    lis_result_t res;
    gap = 0;
    if (idle_enable) begin
      while ($urandom_range(99) < 7) gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_value <= v;
    in_last  <= l;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    // Taken at this edge.
    lis_absorb(v, l, done, res);
    words_sent++;
    if (done) lis_pending.push_back(known ? typed : res);
  endtask

  // Sender pause: drop start and let every owed result word come out.
  task automatic wait_drained();
    start <= 1'b0;
    while (lis_pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value(input flavor_t flavor,
                                                         input logic signed [VAL_W-1:0] prev);
    logic signed [VAL_W-1:0] v;
    case (flavor)
      FLAVOR_NARROW: v = $signed(VAL_W'($urandom_range(16))) - 32'sd8;
      FLAVOR_WIDE:   v = $signed($urandom());
      FLAVOR_CLIMB:  v = prev + $signed(VAL_W'($urandom_range(6))) - 32'sd2;
      default: begin
        case ($urandom_range(7))
          0:       v = VAL_MIN;
          1:       v = VAL_MAX;
          2:       v = -32'sd1;
          3:       v = 32'sd0;
          4:       v = 32'sd1;
          5:       v = VAL_MIN + 32'sd1;
          6:       v = VAL_MAX - 32'sd1;
          default: v = $signed($urandom());
        endcase
      end
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: a strobed word is taken at the edge closing its cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_strobe !== 1'b0) begin
      results_seen++;
      if (out_overflow === 1'b1) overflow_results++;
      if (out_length > longest_seen) longest_seen = out_length;
      if (lis_pending.size() == 0) begin
        flag_error($sformatf("result word with none owed: length=%0d overflow=%0b",
                             out_length, out_overflow));
      end else begin
        want_result = lis_pending.pop_front();
        if (out_length !== want_result.length)
          flag_error($sformatf("length: expected %0d, got %0d",
                               want_result.length, out_length));
        if (out_overflow !== want_result.overflow)
          flag_error($sformatf("overflow: expected %0b, got %0b",
                               want_result.overflow, out_overflow));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d result words owed",
               cycle_count, lis_pending.size());
      $display("FAIL longest_increasing_subsequence_top");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned             r;
    int unsigned             k;
    int unsigned             run_len;
    int unsigned             roll;
    int unsigned             random_words;
    int unsigned             sequences;
    flavor_t                 flavor;
    logic signed [VAL_W-1:0] prev;

    random_words = 0;
    sequences    = 0;
    rst_n    <= 1'b0;
    start    <= 1'b0;
    in_value <= '0;
    in_last  <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table.
    for (r = 0; r < DIRECTED_ROWS; r++) begin
      send_word(directed_rows[r].value, directed_rows[r].last, directed_rows[r].known,
                '{directed_rows[r].length, directed_rows[r].overflow});
      if (directed_rows[r].last) sequences++;
    end

    // Hold off until the directed results are all in.
    wait_drained();

    // Random sequences, mostly short so each one finishes quickly; idling
    // is switched off for a stretch in the middle.
    while (random_words < RANDOM_WORDS) begin
      idle_enable = (random_words < 200 || random_words >= 320);
      roll = $urandom_range(99);
      if (roll < 55) begin
        flavor  = FLAVOR_NARROW;
        run_len = $urandom_range(16, 1);
      end else if (roll < 75) begin
        flavor  = FLAVOR_WIDE;
        run_len = $urandom_range(10, 1);
      end else if (roll < 88) begin
        flavor  = FLAVOR_CLIMB;
        run_len = $urandom_range(40, 10);
      end else begin
        flavor  = FLAVOR_CORNER;
        run_len = $urandom_range(8, 1);
      end
      prev = $signed(VAL_W'($urandom_range(200))) - 32'sd100;
      for (k = 0; k < run_len; k++) begin
        prev = pick_value(flavor, prev);
        send_word(prev, k == run_len - 1, 1'b0, '0);
        random_words++;
      end
      sequences++;
    end

    wait_drained();
    repeat (MAX_N + 8) @(posedge clk);

    $display("Ran %0d words in %0d sequences (directed edge cases, then random runs);",
             words_sent, sequences);
    $display("checked %0d result words, %0d with overflow, longest length %0d.",
             results_seen, overflow_results, longest_seen);
    if (mismatches == 0 && lis_pending.size() == 0) begin
      $display("PASS longest_increasing_subsequence_top");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL longest_increasing_subsequence_top");
    end
    $finish;
  end

endmodule
